// ===== rtl/rpc_pkg.sv =====
package rpc_pkg;

  // wall geometry
  localparam int WALL_CELLS = 64;
  localparam int IDX_W      = $clog2(WALL_CELLS);
  localparam int CFG_W      = 6;
  localparam int RANGE_W    = 6;
  localparam int COLOR_W    = 8;

  // cleared cell color ('_')
  localparam logic [COLOR_W-1:0] BLANK_COLOR = 8'd95;

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register index, taken from paddr[2]
  localparam logic REG_WALL_LENGTH = 1'b0;

  // request kinds
  localparam logic REQ_PAINT = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAINT,
    ST_QRUN,
    ST_QLAST,
    ST_ERR
  } rpc_state_t;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic load;
    logic paint_wr;
    logic q_step;
    logic q_last;
    logic err_push;
  } rpc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic accept;
    logic in_query;
    logic in_invalid;
    logic at_end;
    logic run_break;
    logic slot_free;
  } rpc_sts_t;

endpackage

// ===== rtl/rpc_chan_if.sv =====
interface rpc_in_if import rpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [RANGE_W-1:0] range_left;
  logic [RANGE_W-1:0] range_right;
  logic [COLOR_W-1:0] paint_color;

  modport source (
    output valid, req_type, range_left, range_right, paint_color,
    input  ready
  );
  modport sink (
    input  valid, req_type, range_left, range_right, paint_color,
    output ready
  );
endinterface

interface rpc_out_if import rpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] run_color;
  logic               last_run;
  logic               range_error;

  modport source (
    output valid, run_color, last_run, range_error,
    input  ready
  );
  modport sink (
    input  valid, run_color, last_run, range_error,
    output ready
  );
endinterface

// ===== rtl/rpc_ram.sv =====
module rpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rpc_ctrl.sv =====
module rpc_ctrl import rpc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  rpc_sts_t sts,
  output rpc_cmd_t cmd
);

  rpc_state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r) inside
      ST_IDLE: begin
        if (sts.accept) begin
          if (sts.in_invalid) begin
            state_nxt = sts.in_query ? ST_ERR : ST_IDLE;
          end else begin
            state_nxt = sts.in_query ? ST_QRUN : ST_PAINT;
          end
        end
      end
      ST_PAINT: begin
        if (sts.at_end) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QRUN: begin
        if ((!sts.run_break || sts.slot_free) && sts.at_end) begin
          state_nxt = ST_QLAST;
        end
      end
      ST_QLAST, ST_ERR: begin
        if (sts.slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.load     = sts.accept;
      end
      ST_PAINT: cmd.paint_wr = 1'b1;
      ST_QRUN:  cmd.q_step   = !sts.run_break || sts.slot_free;
      ST_QLAST: cmd.q_last   = sts.slot_free;
      ST_ERR:   cmd.err_push = sts.slot_free;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/rpc_dp.sv =====
module rpc_dp import rpc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CFG_W-1:0] wall_length,
  rpc_in_if.sink           in_ch,
  rpc_out_if.source        out_ch,
  input  rpc_cmd_t         cmd,
  output rpc_sts_t         sts
);

  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   right_r, right_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic               pend_vld_r, pend_vld_nxt;
  logic [COLOR_W-1:0] pend_color_r, pend_color_nxt;
  logic [WALL_CELLS-1:0] vld_r, vld_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [COLOR_W-1:0] out_color_r, out_color_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_err_r, out_err_nxt;

  logic [CFG_W-1:0]   wall_end;
  logic [CFG_W-1:0]   right_clip;
  logic [IDX_W-1:0]   idx_inc;
  logic [IDX_W-1:0]   rd_addr;
  logic [COLOR_W-1:0] ram_q;
  logic [COLOR_W-1:0] cur_color;
  logic               push_run;
  logic               push;

  // wall end and right-edge clip of the incoming request
  always_comb begin
    if (wall_length > CFG_W'(WALL_CELLS - 1)) begin
      wall_end = CFG_W'(WALL_CELLS - 1);
    end else begin
      wall_end = wall_length;
    end
    right_clip = (in_ch.range_right > wall_end) ? wall_end : in_ch.range_right;
  end

  assign idx_inc   = idx_r + IDX_W'(1);
  assign cur_color = rd_vld_r ? ram_q : BLANK_COLOR;

  // status for the controller
  always_comb begin
    sts.accept     = in_ch.valid && in_ch.ready;
    sts.in_query   = (in_ch.req_type == REQ_QUERY);
    sts.in_invalid = (in_ch.range_left > in_ch.range_right) ||
                     (in_ch.range_left > wall_end);
    sts.at_end     = (idx_r == right_r);
    sts.run_break  = pend_vld_r && (cur_color != pend_color_r);
    sts.slot_free  = !out_vld_r || out_ch.ready;
  end

  assign in_ch.ready = cmd.in_ready;

  // read ahead: address the cell that is current next cycle
  always_comb begin
    if (cmd.load) begin
      rd_addr = in_ch.range_left[IDX_W-1:0];
    end else if (cmd.q_step && !sts.at_end) begin
      rd_addr = idx_inc;
    end else begin
      rd_addr = idx_r;
    end
  end

  rpc_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (WALL_CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (cmd.paint_wr),
    .waddr (idx_r),
    .wdata (color_r),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // request registers, cell index and written-cell flags
  always_comb begin
    idx_nxt    = idx_r;
    right_nxt  = right_r;
    color_nxt  = color_r;
    vld_nxt    = vld_r;
    rd_vld_nxt = vld_r[rd_addr];
    if (cmd.load) begin
      idx_nxt   = in_ch.range_left[IDX_W-1:0];
      right_nxt = right_clip[IDX_W-1:0];
      color_nxt = in_ch.paint_color;
    end
    if (cmd.paint_wr) begin
      vld_nxt[idx_r] = 1'b1;
    end
    if ((cmd.paint_wr || cmd.q_step) && !sts.at_end) begin
      idx_nxt = idx_inc;
    end
  end

  // pending run: held until the next color change or the range end
  assign push_run = cmd.q_step && sts.run_break;
  assign push     = push_run || cmd.q_last || cmd.err_push;

  always_comb begin
    pend_vld_nxt   = pend_vld_r;
    pend_color_nxt = pend_color_r;
    if (cmd.load) begin
      pend_vld_nxt = 1'b0;
    end else if (cmd.q_step && (!pend_vld_r || sts.run_break)) begin
      pend_vld_nxt   = 1'b1;
      pend_color_nxt = cur_color;
    end
  end

  // output register
  always_comb begin
    out_color_nxt = out_color_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    if (push) begin
      out_vld_nxt   = 1'b1;
      out_color_nxt = cmd.err_push ? '0 : pend_color_r;
      out_last_nxt  = cmd.q_last || cmd.err_push;
      out_err_nxt   = cmd.err_push;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.run_color   = out_color_r;
  assign out_ch.last_run    = out_last_r;
  assign out_ch.range_error = out_err_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      vld_r      <= vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    right_r      <= right_nxt;
    color_r      <= color_nxt;
    rd_vld_r     <= rd_vld_nxt;
    pend_color_r <= pend_color_nxt;
    out_color_r  <= out_color_nxt;
    out_last_r   <= out_last_nxt;
    out_err_r    <= out_err_nxt;
  end

endmodule

// ===== rtl/range_paint_color_runs_top.sv =====
// Wall of 64 colored cells with range paint and color-run queries.
// in_ch (valid/ready) carries requests: req_type 0 paints paint_color over
// range_left..range_right, req_type 1 asks for the color runs of that range.
// out_ch (valid/ready) returns one result per run, left to right, with
// last_run on the final one; an invalid query range gives a single result
// with range_error and last_run set and run_color zero. Paints give nothing.
// The APB port holds wall_length at address 0; ranges are clipped to it.
// Timing: one request at a time. A paint is accepted and then writes one
// painted cell per cycle. A query is accepted, walks one cell per cycle
// (unless stalled, see below) and then gives its final result; the cell
// RAM, with one write and one read port, reads one cell per cycle.
// Results leave through an output register, at most one per cycle; a
// stalled receiver holds the walk at the next color change until the
// register frees. The next request is taken once the last result sits in
// the output register, even if the receiver has not taken it yet.
// Reset (rst_n low, synchronous) clears every cell to '_' via per-cell
// written flags, drops any pending result and sets wall_length to 63.
module range_paint_color_runs_top import rpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  rpc_in_if.sink            in_ch,
  rpc_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [CFG_W-1:0] wall_length_r, wall_length_nxt;
  logic             cfg_wr;
  rpc_cmd_t         cmd;
  rpc_sts_t         sts;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    wall_length_nxt = wall_length_r;
    if (cfg_wr && (paddr[2] == REG_WALL_LENGTH)) begin
      wall_length_nxt = pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WALL_LENGTH: prdata = {{(APB_DW - CFG_W){1'b0}}, wall_length_r};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_length_r <= CFG_W'(63);
    end else begin
      wall_length_r <= wall_length_nxt;
    end
  end

  rpc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  rpc_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .wall_length (wall_length_r),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

// ===== rtl/rpc_chk.sv =====
module rpc_chk import rpc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COLOR_W-1:0] run_color,
  input logic               last_run,
  input logic               range_error,
  input logic               pready
);

  // a result waits until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // an error result is a lone, zero-colored last result
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && range_error |-> last_run && (run_color == '0))
    else $error("malformed range error result");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(run_color) && $stable(last_run) && $stable(range_error))
    else $error("result changed while stalled");

  // the configuration port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready low");

endmodule

bind range_paint_color_runs_top rpc_chk u_rpc_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .run_color   (out_ch.run_color),
  .last_run    (out_ch.last_run),
  .range_error (out_ch.range_error),
  .pready      (pready)
);
